### sv/i2cm_pkg.sv
// shared types and constants for the i2c register access master
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

  // command codes carried in the opcode field
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_PROBE = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] dev_address;
    logic [7:0] reg_index;
    logic [7:0] write_value;
    logic       sda_in;
  } tick_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [7:0] read_data;
  } tick_out_t;

endpackage : i2cm_pkg
`default_nettype wire

### sv/i2cm_core.sv
// bus sequencer: advances the i2c transaction state by one tick per word
`timescale 1ns / 1ps
`default_nettype none
module i2cm_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire i2cm_pkg::tick_in_t    tick_in,
  input  wire logic [15:0]           half_period_ticks,
  output i2cm_pkg::tick_out_t        tick_out
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_A   = 5'd1,
    PH_ST_B   = 5'd2,
    PH_ST_C   = 5'd3,
    PH_WB_SET = 5'd4,
    PH_WB_HI  = 5'd5,
    PH_WB_LO  = 5'd6,
    PH_WA_SET = 5'd7,
    PH_WA_HI  = 5'd8,
    PH_WA_LO  = 5'd9,
    PH_RB_HI  = 5'd10,
    PH_RB_LO  = 5'd11,
    PH_RN_SET = 5'd12,
    PH_RN_HI  = 5'd13,
    PH_RN_LO  = 5'd14,
    PH_SP_A   = 5'd15,
    PH_SP_B   = 5'd16,
    PH_SP_C   = 5'd17
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [1:0]  saved_command, saved_command_next;
  logic [6:0]  saved_address, saved_address_next;
  logic [7:0]  saved_register, saved_register_next;
  logic [7:0]  saved_value, saved_value_next;
  logic        ack_ok, ack_ok_next;
  logic [7:0]  read_byte, read_byte_next;

  logic [15:0] limit;
  logic [3:0]  bit_inc;
  logic        seg_end;
  logic        scl_now;
  logic        sda_now;
  logic        busy_now;
  logic        done_now;

  assign limit   = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  // bit counting phases never coincide with a command tick, so the stored count is current
  assign bit_inc = bit_count + 4'd1;

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    byte_index_next     = byte_index;
    saved_command_next  = saved_command;
    saved_address_next  = saved_address;
    saved_register_next = saved_register;
    saved_value_next    = saved_value;
    ack_ok_next         = ack_ok;
    read_byte_next      = read_byte;
    scl_now             = 1'b1;
    sda_now             = 1'b0;
    busy_now            = 1'b0;
    done_now            = 1'b0;
    seg_end             = 1'b0;

    // a command is latched only on an idle tick, and that tick starts the bus
    if (phase == PH_IDLE && tick_in.opcode != CMD_NONE) begin
      saved_command_next  = tick_in.opcode;
      saved_address_next  = tick_in.dev_address;
      saved_register_next = tick_in.reg_index;
      saved_value_next    = tick_in.write_value;
      ack_ok_next         = 1'b1;
      byte_index_next     = 2'd0;
      bit_count_next      = 4'd0;
      tick_count_next     = 16'd0;
      phase_next          = PH_ST_A;
    end

    if (phase_next != PH_IDLE) begin
      unique case (phase_next)
        PH_ST_A:   begin scl_now = 1'b1; sda_now = 1'b0; end
        PH_ST_B:   begin scl_now = 1'b1; sda_now = 1'b1; end
        PH_ST_C:   begin scl_now = 1'b0; sda_now = 1'b1; end
        PH_WB_SET: begin scl_now = 1'b0; sda_now = ~shift_byte_next[7]; end
        PH_WB_HI:  begin scl_now = 1'b1; sda_now = ~shift_byte_next[7]; end
        PH_WB_LO:  begin scl_now = 1'b0; sda_now = ~shift_byte_next[7]; end
        PH_WA_HI,
        PH_RB_HI,
        PH_RN_HI,
        PH_SP_C:   begin scl_now = 1'b1; sda_now = 1'b0; end
        PH_SP_A:   begin scl_now = 1'b0; sda_now = 1'b1; end
        PH_SP_B:   begin scl_now = 1'b1; sda_now = 1'b1; end
        default:   begin scl_now = 1'b0; sda_now = 1'b0; end
      endcase

      seg_end = ({1'b0, tick_count_next} + 17'd1) >= {1'b0, limit};
      if (seg_end) begin
        tick_count_next = 16'd0;
        unique case (phase_next)
          PH_ST_A: phase_next = PH_ST_B;
          PH_ST_B: phase_next = PH_ST_C;
          PH_ST_C: begin
            // second start of a read sends the address with the read bit
            shift_byte_next = {saved_address_next, (byte_index_next != 2'd0)};
            bit_count_next  = 4'd0;
            phase_next      = PH_WB_SET;
          end
          PH_WB_SET: phase_next = PH_WB_HI;
          PH_WB_HI:  phase_next = PH_WB_LO;
          PH_WB_LO: begin
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            bit_count_next  = bit_inc;
            phase_next      = (bit_inc >= 4'd8) ? PH_WA_SET : PH_WB_SET;
          end
          PH_WA_SET: phase_next = PH_WA_HI;
          PH_WA_HI: begin
            if (tick_in.sda_in) begin
              ack_ok_next = 1'b0;
            end
            phase_next = PH_WA_LO;
          end
          PH_WA_LO: begin
            priority if (!ack_ok_next || saved_command_next == CMD_PROBE) begin
              phase_next = PH_SP_A;
            end else if (byte_index_next == 2'd0) begin
              byte_index_next = 2'd1;
              shift_byte_next = saved_register_next;
              bit_count_next  = 4'd0;
              phase_next      = PH_WB_SET;
            end else if (saved_command_next == CMD_WRITE) begin
              if (byte_index_next == 2'd1) begin
                byte_index_next = 2'd2;
                shift_byte_next = saved_value_next;
                bit_count_next  = 4'd0;
                phase_next      = PH_WB_SET;
              end else begin
                phase_next = PH_SP_A;
              end
            end else if (byte_index_next == 2'd1) begin
              byte_index_next = 2'd2;
              phase_next      = PH_ST_A;
            end else begin
              shift_byte_next = 8'd0;
              bit_count_next  = 4'd0;
              phase_next      = PH_RB_HI;
            end
          end
          PH_RB_HI: begin
            shift_byte_next = {shift_byte_next[6:0], tick_in.sda_in};
            phase_next      = PH_RB_LO;
          end
          PH_RB_LO: begin
            bit_count_next = bit_inc;
            phase_next     = (bit_inc >= 4'd8) ? PH_RN_SET : PH_RB_HI;
          end
          PH_RN_SET: phase_next = PH_RN_HI;
          PH_RN_HI:  phase_next = PH_RN_LO;
          PH_RN_LO:  phase_next = PH_SP_A;
          PH_SP_A:   phase_next = PH_SP_B;
          PH_SP_B:   phase_next = PH_SP_C;
          default: begin
            if (ack_ok_next && saved_command_next == CMD_READ) begin
              read_byte_next = shift_byte_next;
            end
            phase_next = PH_IDLE;
            done_now   = 1'b1;
          end
        endcase
      end else begin
        tick_count_next = tick_count_next + 16'd1;
      end
      busy_now = ~done_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      bit_count      <= '0;
      shift_byte     <= '0;
      byte_index     <= '0;
      saved_command  <= CMD_NONE;
      saved_address  <= '0;
      saved_register <= '0;
      saved_value    <= '0;
      ack_ok         <= 1'b1;
      read_byte      <= '0;
    end else if (step) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      byte_index     <= byte_index_next;
      saved_command  <= saved_command_next;
      saved_address  <= saved_address_next;
      saved_register <= saved_register_next;
      saved_value    <= saved_value_next;
      ack_ok         <= ack_ok_next;
      read_byte      <= read_byte_next;
    end
  end

  assign tick_out.scl_level    = scl_now;
  assign tick_out.sda_pull_low = sda_now;
  assign tick_out.busy_res     = busy_now;
  assign tick_out.done_res     = done_now;
  assign tick_out.success      = done_now & ack_ok_next;
  assign tick_out.read_data    = read_byte_next;

endmodule : i2cm_core
`default_nettype wire

### sv/i2c_master_register_access.sv
// i2c master for single register probe, write and read, one bus tick per word
//
// the input stream carries one word per bus tick: the sampled sda level and
// an optional command (probe, register write, register read) that is taken
// only while the bus is idle. every input word yields exactly one output
// word with the scl and sda drive levels, busy, done, success and the last
// byte read. each bus phase is half_period_ticks words (0 counts as 1, reset
// value 5), set via cfg_wr_en / cfg_wr_data; the user must write it only while
// idle, not enforced by the block. each word goes through the sequencer into
// an output register: the result appears in the cycle after acceptance, and a
// new word can be taken every cycle, also in the cycle the held result is
// taken. when the output side stalls, the output register holds its word and
// s_tready drops until it is taken, so the bus state advances only on accepted
// words. synchronous reset returns the sequencer to idle (scl high, sda
// released), empties the output register and sets the half period back to 5.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_register_access (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[1:0], dev_address[8:2], reg_index[16:9], write_value[24:17],
  // sda_in[25], zero fill[31:26]
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // scl_level[0], sda_pull_low[1], busy_res[2], done_res[3], success[4],
  // read_data[12:5], zero fill[15:13]
  output logic [15:0]      m_tdata
);
  import i2cm_pkg::*;

  logic [15:0] half_period_ticks;
  tick_in_t    tick_in;
  tick_out_t   tick_out;
  logic        step;
  logic [15:0] out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= 16'd5;
    end else if (cfg_wr_en) begin
      half_period_ticks <= cfg_wr_data;
    end
  end

  assign tick_in.opcode      = s_tdata[1:0];
  assign tick_in.dev_address = s_tdata[8:2];
  assign tick_in.reg_index   = s_tdata[16:9];
  assign tick_in.write_value = s_tdata[24:17];
  assign tick_in.sda_in      = s_tdata[25];

  assign s_tready = ~m_tvalid | m_tready;
  assign step     = s_tvalid & s_tready;

  i2cm_core u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .tick_in           (tick_in),
    .half_period_ticks (half_period_ticks),
    .tick_out          (tick_out)
  );

  assign out_word = {3'b000, tick_out.read_data, tick_out.success, tick_out.done_res,
                     tick_out.busy_res, tick_out.sda_pull_low, tick_out.scl_level};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= out_word;
    end
  end

endmodule : i2c_master_register_access
`default_nettype wire

### sv/i2cm_checker.sv
// port-level checks for the i2c register access master, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module i2cm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // a stalled output word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // the end of a transaction is never also a busy word
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("done and busy together");

  // success is reported only with done
  a_success_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[3])
    else $error("success without done");

  // outside a transaction the bus rests with scl high and sda released
  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[0] && !m_tdata[1])
    else $error("bus not at rest outside a transaction");

endmodule : i2cm_checker

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
